// ===== rtl/core/ipr_pkg.sv =====
// Shared constants and types for the isolated pixel removal block.
package ipr_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_PIXEL_BITS = 16;

	localparam int IMG_W_BITS    = 11;
	localparam int IMG_H_BITS    = 16;
	localparam int ROW_EXT_BITS  = IMG_H_BITS + 1;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;
	localparam int WIN_BITS      = 9;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST  = 11'd10;
	localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RST = 16'd10;

	// Per-word control bits that travel from the front end to the window stage.
	typedef struct packed {
		logic emit;
		logic final_px;
		logic first_col;
		logic mid_ok;
		logic top_ok;
	} ipr_ctl_t;

endpackage

// ===== rtl/core/ipr_intf.sv =====
// Stream and configuration channel interfaces of the isolated pixel removal block.
interface ipr_pix_in_if #(
	parameter int PIXEL_BITS = ipr_pkg::DEF_PIXEL_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [PIXEL_BITS-1:0] pixel_in;
	logic                         flush;

	modport source (output valid, output pixel_in, output flush, input ready);
	modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

interface ipr_pix_out_if #(
	parameter int PIXEL_BITS = ipr_pkg::DEF_PIXEL_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [PIXEL_BITS-1:0] pixel_out;
	logic                         frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface ipr_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [ipr_pkg::CFG_IDX_BITS-1:0]     index;
	logic [ipr_pkg::CFG_DATA_BITS-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/isolated_pixel_removal.sv =====
// Isolated pixel removal: top level tying configuration, front end, line store and window.
// Streams an image in raster order, one word per pixel, and clears every nonzero pixel whose
// eight neighbors are all zero (neighbors outside the image count as zero). The block takes
// one word per clock unless the output stalls; each pixel leaves image_width+1 accepted
// words after it arrived. After the frame's last pixel, image_width+1 more words, flush or
// not, drain the remaining pixels and the final one carries frame_last. A flush word with no
// frame open is taken and dropped, and an early flush inside a frame counts as a zero pixel.
// Two register stages sit between the ports (input stage with the line store read, then the
// output register); the rate of one word per clock is set by the single read and single
// write the line store makes for each word. The line store needs no clearing after reset.
// Width is used clamped to 1..MAX_WIDTH and a zero height counts as one row.
module isolated_pixel_removal
	import ipr_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	ipr_pix_in_if.sink    pix_in,
	ipr_pix_out_if.source pix_out,
	ipr_cfg_if.sink       cfg
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int UW = (IMG_W_BITS > CW + 1) ? IMG_W_BITS : CW + 1;

	logic [UW-1:0]         used_w;
	logic [IMG_H_BITS-1:0] used_h;
	logic                  s1_advance;
	logic                  rd_en;
	logic [CW-1:0]         rd_addr;
	logic [PIXEL_BITS:0]   rd_data;
	logic                  s1_valid;
	ipr_ctl_t              s1_ctl;
	logic [PIXEL_BITS-1:0] s1_v;
	logic [CW-1:0]         s1_addr;
	logic                  wr_en;
	logic [CW-1:0]         wr_addr;
	logic [PIXEL_BITS:0]   wr_data;

	ipr_cfg_regs #(
		.MAX_WIDTH (MAX_WIDTH),
		.UW        (UW)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.used_w (used_w),
		.used_h (used_h)
	);

	ipr_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS),
		.CW         (CW),
		.UW         (UW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in),
		.used_w     (used_w),
		.used_h     (used_h),
		.s1_advance (s1_advance),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.s1_valid   (s1_valid),
		.s1_ctl     (s1_ctl),
		.s1_v       (s1_v),
		.s1_addr    (s1_addr)
	);

	ipr_line_mem #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS),
		.CW         (CW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	ipr_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS),
		.CW         (CW)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.s1_ctl     (s1_ctl),
		.s1_v       (s1_v),
		.s1_addr    (s1_addr),
		.rd_data    (rd_data),
		.s1_advance (s1_advance),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.pix_out    (pix_out)
	);

endmodule

// ===== rtl/core/ipr_cfg_regs.sv =====
// Configuration registers with the clamped width and height used by the datapath.
module ipr_cfg_regs
	import ipr_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int UW        = IMG_W_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ipr_cfg_if.sink               cfg,
	output logic [UW-1:0]         used_w,
	output logic [IMG_H_BITS-1:0] used_h
);

	logic [IMG_W_BITS-1:0] image_width_q;
	logic [IMG_H_BITS-1:0] image_height_q;
	logic [UW-1:0]         width_ext;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg.data[IMG_W_BITS-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg.data[IMG_H_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign width_ext = UW'(image_width_q);

	always_comb begin
		if (image_width_q == '0)
			used_w = UW'(1);
		else if (width_ext > UW'(MAX_WIDTH))
			used_w = UW'(MAX_WIDTH);
		else
			used_w = width_ext;
	end

	assign used_h = (image_height_q == '0) ? IMG_H_BITS'(1) : image_height_q;

endmodule

// ===== rtl/core/ipr_line_mem.sv =====
// Line store holding the latest row's values and the row before's nonzero flags.
module ipr_line_mem
	import ipr_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int CW         = $clog2(MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [CW-1:0]       rd_addr,
	output logic [PIXEL_BITS:0] rd_data,
	input  logic                wr_en,
	input  logic [CW-1:0]       wr_addr,
	input  logic [PIXEL_BITS:0] wr_data
);

	logic [PIXEL_BITS:0] mem [MAX_WIDTH];
	logic [PIXEL_BITS:0] rd_q;

	// A word that reads the entry the previous word writes in the same cycle
	// takes the new data directly (this happens with a one-pixel row).
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr))
				rd_q <= wr_data;
			else
				rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/core/ipr_front.sv =====
// Position tracking, drain sequencing and the input register stage.
module ipr_front
	import ipr_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int CW         = $clog2(MAX_WIDTH),
	parameter int UW         = IMG_W_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ipr_pix_in_if.sink            pix_in,
	input  logic [UW-1:0]         used_w,
	input  logic [IMG_H_BITS-1:0] used_h,
	input  logic                  s1_advance,
	output logic                  rd_en,
	output logic [CW-1:0]         rd_addr,
	output logic                  s1_valid,
	output ipr_ctl_t              s1_ctl,
	output logic [PIXEL_BITS-1:0] s1_v,
	output logic [CW-1:0]         s1_addr
);

	logic                    draining_q;
	logic [CW:0]             drain_k_q;
	logic [CW-1:0]           col_q;
	logic [IMG_H_BITS-1:0]   row_q;

	logic                    s1_valid_q;
	ipr_ctl_t                ctl_s1;
	logic [PIXEL_BITS-1:0]   v_s1;
	logic [CW-1:0]           addr_s1;

	logic                    accept;
	logic                    skip;
	logic                    load;
	logic                    k_ge_w;
	logic [ROW_EXT_BITS-1:0] h_ext;
	logic [ROW_EXT_BITS-1:0] r;
	logic [CW-1:0]           c;
	logic                    v_zero;
	logic [PIXEL_BITS-1:0]   v;
	logic                    row_end;
	logic                    frame_end;
	ipr_ctl_t                ctl;

	assign pix_in.ready = !s1_valid_q || s1_advance;
	assign accept       = pix_in.valid && pix_in.ready;

	assign h_ext  = ROW_EXT_BITS'(used_h);
	assign k_ge_w = UW'(drain_k_q) >= used_w;

	always_comb begin
		if (draining_q) begin
			r = h_ext + ROW_EXT_BITS'(k_ge_w);
			c = k_ge_w ? '0 : drain_k_q[CW-1:0];
		end else begin
			r = ROW_EXT_BITS'(row_q);
			c = col_q;
		end
	end

	// A flush word with no frame open is taken and dropped.
	assign skip = !draining_q && pix_in.flush && (row_q == '0) && (col_q == '0);
	assign load = accept && !skip;

	assign v_zero = draining_q || pix_in.flush || (r >= h_ext);
	assign v      = v_zero ? '0 : pix_in.pixel_in;

	assign ctl.top_ok    = (r >= ROW_EXT_BITS'(2)) && ((r - ROW_EXT_BITS'(2)) < h_ext);
	assign ctl.mid_ok    = (r >= ROW_EXT_BITS'(1)) && ((r - ROW_EXT_BITS'(1)) < h_ext);
	assign ctl.first_col = (c == '0);
	assign ctl.final_px  = draining_q && k_ge_w;
	assign ctl.emit      = (r >= ROW_EXT_BITS'(2)) || ((r == ROW_EXT_BITS'(1)) && (c != '0));

	assign row_end   = (UW'(c) + UW'(1)) >= used_w;
	assign frame_end = (r + ROW_EXT_BITS'(1)) >= h_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			drain_k_q  <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (load) begin
			if (draining_q) begin
				if (k_ge_w) begin
					draining_q <= 1'b0;
					drain_k_q  <= '0;
					col_q      <= '0;
					row_q      <= '0;
				end else begin
					drain_k_q <= drain_k_q + (CW+1)'(1);
				end
			end else if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q      <= '0;
					draining_q <= 1'b1;
					drain_k_q  <= '0;
				end else begin
					row_q <= row_q + IMG_H_BITS'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (load)
			s1_valid_q <= 1'b1;
		else if (s1_advance)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctl_s1  <= ctl;
			v_s1    <= v;
			addr_s1 <= c;
		end
	end

	assign rd_en    = load;
	assign rd_addr  = c;
	assign s1_valid = s1_valid_q;
	assign s1_ctl   = ctl_s1;
	assign s1_v     = v_s1;
	assign s1_addr  = addr_s1;

endmodule

// ===== rtl/core/ipr_window.sv =====
// 3x3 flag window, isolation test and output register.
module ipr_window
	import ipr_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int CW         = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s1_valid,
	input  ipr_ctl_t              s1_ctl,
	input  logic [PIXEL_BITS-1:0] s1_v,
	input  logic [CW-1:0]         s1_addr,
	input  logic [PIXEL_BITS:0]   rd_data,
	output logic                  s1_advance,
	output logic                  wr_en,
	output logic [CW-1:0]         wr_addr,
	output logic [PIXEL_BITS:0]   wr_data,
	ipr_pix_out_if.source         pix_out
);

	logic [WIN_BITS-1:0]   win_q;
	logic [PIXEL_BITS-1:0] center_q;
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] out_pixel_q;
	logic                  out_last_q;

	logic [PIXEL_BITS-1:0] mid_val;
	logic                  mid_nz;
	logic [2:0]            newcol;
	logic [WIN_BITS-1:0]   win_sh;
	logic [WIN_BITS-1:0]   win1;
	logic [WIN_BITS-1:0]   win2;
	logic                  lonely;
	logic [PIXEL_BITS-1:0] out_val;

	assign s1_advance = s1_valid && (!out_valid_q || pix_out.ready);

	assign mid_val = s1_ctl.mid_ok ? rd_data[PIXEL_BITS-1:0] : '0;
	assign mid_nz  = |mid_val;
	assign newcol  = {|s1_v, mid_nz, s1_ctl.top_ok & rd_data[PIXEL_BITS]};

	// At the start of a row an empty column first closes the previous row's
	// right edge; the new column enters after the test.
	assign win_sh = {3'b000, win_q[WIN_BITS-1:3]};
	assign win1   = s1_ctl.first_col ? win_sh : (win_sh | {newcol, 6'b000000});
	assign win2   = s1_ctl.first_col ? ({3'b000, win1[WIN_BITS-1:3]} | {newcol, 6'b000000})
	                                 : win1;

	assign lonely  = ({win1[8:5], win1[3:0]} == 8'h00);
	assign out_val = ((|center_q) && lonely) ? '0 : center_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			center_q <= '0;
		end else if (s1_advance) begin
			if (s1_ctl.final_px) begin
				win_q    <= '0;
				center_q <= '0;
			end else begin
				win_q    <= win2;
				center_q <= mid_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_advance && s1_ctl.emit)
			out_valid_q <= 1'b1;
		else if (pix_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_advance && s1_ctl.emit) begin
			out_pixel_q <= out_val;
			out_last_q  <= s1_ctl.final_px;
		end
	end

	assign wr_en   = s1_advance;
	assign wr_addr = s1_addr;
	assign wr_data = {mid_nz, s1_v};

	assign pix_out.valid      = out_valid_q;
	assign pix_out.pixel_out  = out_pixel_q;
	assign pix_out.frame_last = out_last_q;

endmodule

// ===== tb/tb.sv =====
// Testbench for the isolated pixel removal block: directed and random frames against a predictor.
module tb;
	import ipr_pkg::*;

	localparam int WIDTH_CAP    = DEF_MAX_WIDTH;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_WORDS = 250;

	typedef struct packed {
		logic signed [DEF_PIXEL_BITS-1:0] value;
		logic                             frame_end;
	} out_word_t;

	logic clk;
	logic arst_n;

	ipr_pix_in_if  #(.PIXEL_BITS(DEF_PIXEL_BITS)) in_ch ();
	ipr_pix_out_if #(.PIXEL_BITS(DEF_PIXEL_BITS)) out_ch ();
	ipr_cfg_if                                    cfg_ch ();

	isolated_pixel_removal u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (in_ch),
		.pix_out(out_ch),
		.cfg    (cfg_ch)
	);

	// Predicted geometry and window state of the block.
	logic [IMG_W_BITS-1:0]     width_reg;
	logic [IMG_H_BITS-1:0]     height_reg;
	logic [DEF_PIXEL_BITS-1:0] line_vals [WIDTH_CAP];
	bit                        line_flags [WIDTH_CAP];
	bit [8:0]                  win_flags;
	logic [DEF_PIXEL_BITS-1:0] centre_hold;
	int unsigned               col_pos;
	int unsigned               row_pos;
	int unsigned               drain_pos;

	out_word_t pixel_due_q[$];

	int errors;
	int words_sent;
	int results_seen;
	int hold_request;
	bit src_quiet;
	bit sink_quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int wait_draw(input bit quiet);
		if (quiet || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic bit frame_open();
		return row_pos != 0 || col_pos != 0 || drain_pos != 0;
	endfunction

	function automatic logic [15:0] width_word(input int w);
		logic [15:0] word;
		word = 16'($urandom);
		word[IMG_W_BITS-1:0] = IMG_W_BITS'(w);
		return word;
	endfunction

	function automatic logic signed [DEF_PIXEL_BITS-1:0] draw_pixel(input int dens);
		logic [DEF_PIXEL_BITS-1:0] raw;
		if ($urandom_range(0, 99) >= dens)
			return '0;
		case ($urandom_range(0, 5))
			0: raw = 16'h7FFF;
			1: raw = 16'h8000;
			2: raw = 16'h0001;
			3: raw = 16'hFFFF;
			default: raw = DEF_PIXEL_BITS'($urandom);
		endcase
		return raw;
	endfunction

	// Works out what one accepted word produces and advances the predicted state.
	task automatic predict_removal(input logic signed [DEF_PIXEL_BITS-1:0] px, input bit fl);
		int unsigned w, h, k, r, c, ci;
		bit draining, top_ok, mid_ok, fin, lonely;
		logic [DEF_PIXEL_BITS-1:0] v, mid_v;
		bit [2:0] newcol;
		out_word_t due;
		w = (width_reg == 0) ? 1 : ((width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg);
		h = (height_reg == 0) ? 1 : height_reg;
		draining = drain_pos != 0;
		fin = 1'b0;
		if (draining) begin
			k = drain_pos - 1;
			r = h + ((k >= w) ? 1 : 0);
			c = (k < w) ? k : 0;
			fin = k >= w;
		end else begin
			// A flush word with no frame open is dropped without trace.
			if (fl && row_pos == 0 && col_pos == 0)
				return;
			r = row_pos;
			c = col_pos;
		end
		v = (draining || fl || r >= h) ? '0 : px;
		top_ok = r >= 2 && r - 2 < h;
		mid_ok = r >= 1 && r - 1 < h;
		ci = (c < WIDTH_CAP) ? c : WIDTH_CAP - 1;
		mid_v = mid_ok ? line_vals[ci] : '0;
		newcol = {v != 0, mid_v != 0, top_ok && line_flags[ci]};
		// At the start of a row an empty column closes the right edge of the row before.
		if (c == 0)
			win_flags = win_flags >> 3;
		else
			win_flags = (win_flags >> 3) | {newcol, 6'd0};
		if (r >= 2 || (r == 1 && c >= 1)) begin
			lonely = (win_flags & 9'h1EF) == 0;
			due.value = (centre_hold != 0 && lonely) ? '0 : centre_hold;
			due.frame_end = fin;
			pixel_due_q.push_back(due);
		end
		if (c == 0)
			win_flags = (win_flags >> 3) | {newcol, 6'd0};
		centre_hold = mid_v;
		line_flags[ci] = mid_v != 0;
		line_vals[ci] = v;
		if (draining) begin
			if (fin) begin
				drain_pos = 0;
				row_pos = 0;
				col_pos = 0;
				win_flags = '0;
				centre_hold = '0;
			end else begin
				drain_pos++;
			end
		end else if (c + 1 >= w) begin
			col_pos = 0;
			if (r + 1 >= h) begin
				row_pos = 0;
				drain_pos = 1;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic send_word(input logic signed [DEF_PIXEL_BITS-1:0] px, input bit fl);
		int gap;
		gap = wait_draw(src_quiet);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel_in <= px;
		in_ch.flush <= fl;
		do @(posedge clk); while (!in_ch.ready);
		predict_removal(px, fl);
		words_sent++;
	endtask

	task automatic send_random_word(input int dens);
		if (drain_pos != 0)
			send_word(draw_pixel(50), $urandom_range(0, 3) != 0);
		else
			send_word(draw_pixel(dens), $urandom_range(0, 40) == 0);
	endtask

	task automatic run_frame(input int dens);
		do send_random_word(dens); while (!frame_open());
		while (frame_open())
			send_random_word(dens);
	endtask

	// Stops offering words and waits until every predicted word has come out.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pixel_due_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic program_geom(input logic [15:0] wdata, input logic [15:0] hdata);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_IMAGE_WIDTH;
		cfg_ch.data <= wdata;
		do @(posedge clk); while (!cfg_ch.ready);
		width_reg = wdata[IMG_W_BITS-1:0];
		cfg_ch.index <= REG_IMAGE_HEIGHT;
		cfg_ch.data <= hdata;
		do @(posedge clk); while (!cfg_ch.ready);
		height_reg = hdata;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_reset_geometry();
		run_frame(30);
		wait_idle();
	endtask

	task automatic test_directed();
		program_geom(16'd3, 16'd3);
		send_word(16'h1234, 1'b1);
		send_word(16'h7FFF, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h8000, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h5555, 1'b1);
		send_word(16'h0000, 1'b0);
		send_word(16'h0001, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b0);
		// The first drain word carries a pixel that must be ignored.
		send_word(16'h2AAA, 1'b0);
		send_word(16'h0000, 1'b1);
		send_word(16'h0000, 1'b1);
		send_word(16'h0000, 1'b1);
		wait_idle();
		// Width zero with the upper data bits set, and height zero: a single pixel frame.
		program_geom(16'hF800, 16'd0);
		send_word(16'hFFFB, 1'b0);
		send_word(16'h0000, 1'b1);
		send_word(16'h7FFF, 1'b0);
		wait_idle();
	endtask

	task automatic test_midframe_config();
		program_geom(width_word(10), 16'd6);
		repeat (3) send_random_word(60);
		wait_idle();
		program_geom(width_word(14), 16'd6);
		while (row_pos < 3 || col_pos < 11)
			send_random_word(60);
		wait_idle();
		// The position is now past both new limits, so the frame goes straight to its drain.
		program_geom(width_word(9), 16'd2);
		while (frame_open())
			send_random_word(60);
		wait_idle();
	endtask

	task automatic test_tall_column();
		program_geom(width_word(1), 16'hFFFF);
		repeat (20) send_random_word(50);
		wait_idle();
		program_geom(width_word(1), 16'd25);
		while (frame_open())
			send_random_word(50);
		wait_idle();
	endtask

	task automatic test_backpressure();
		program_geom(width_word(8), 16'd5);
		src_quiet = 1'b1;
		hold_request = 300;
		run_frame(50);
		src_quiet = 1'b0;
		wait_idle();
	endtask

	// The widest row runs in full; once a few drain words are out, the row is narrowed
	// so that the drain ends at once.
	task automatic test_widest_rows();
		src_quiet = 1'b1;
		program_geom(16'hFFFF, 16'd1);
		do send_random_word(40); while (drain_pos == 0);
		repeat (4) send_random_word(40);
		wait_idle();
		program_geom(width_word(1), 16'd1);
		while (frame_open())
			send_random_word(40);
		wait_idle();
		src_quiet = 1'b0;
	endtask

	task automatic test_random_frames();
		int first, w, h, dens;
		first = words_sent;
		while (words_sent - first < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0)
				w = $urandom_range(1, 48);
			else
				w = $urandom_range(1, 12);
			h = $urandom_range(1, 9);
			case ($urandom_range(0, 3))
				0: dens = 3;
				1: dens = 15;
				2: dens = 40;
				default: dens = 85;
			endcase
			src_quiet = $urandom_range(0, 3) == 0;
			program_geom(width_word(w), 16'(h));
			run_frame(dens);
			wait_idle();
		end
		src_quiet = 1'b0;
	endtask

	// Output side: random stalls per word, and a long hold-off when one is requested.
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else begin
				stall = wait_draw(sink_quiet);
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			results_seen++;
			if (results_seen % 64 == 0)
				sink_quiet = $urandom_range(0, 2) == 0;
		end
	end

	always @(posedge clk) begin : check_word
		out_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pixel_due_q.size() == 0) begin
				$error("unexpected word: pixel_out %0d frame_last %0b",
					$signed(out_ch.pixel_out), out_ch.frame_last);
				errors++;
			end else begin
				want = pixel_due_q.pop_front();
				if (out_ch.pixel_out !== want.value) begin
					$error("pixel_out: expected %0d, got %0d",
						$signed(want.value), $signed(out_ch.pixel_out));
					errors++;
				end
				if (out_ch.frame_last !== want.frame_end) begin
					$error("frame_last: expected %0b, got %0b",
						want.frame_end, out_ch.frame_last);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.pixel_in <= '0;
		in_ch.flush <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_IMAGE_WIDTH;
		cfg_ch.data <= '0;
		width_reg = IMAGE_WIDTH_RST;
		height_reg = IMAGE_HEIGHT_RST;
		foreach (line_vals[i]) begin
			line_vals[i] = '0;
			line_flags[i] = 1'b0;
		end
		win_flags = '0;
		centre_hold = '0;
		col_pos = 0;
		row_pos = 0;
		drain_pos = 0;
		errors = 0;
		words_sent = 0;
		results_seen = 0;
		hold_request = 0;
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_geometry();
		test_directed();
		test_midframe_config();
		test_tall_column();
		test_backpressure();
		test_widest_rows();
		test_random_frames();
		wait_idle();
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ipr_pkg.sv
rtl/core/ipr_intf.sv
rtl/core/ipr_cfg_regs.sv
rtl/core/ipr_line_mem.sv
rtl/core/ipr_front.sv
rtl/core/ipr_window.sv
rtl/core/isolated_pixel_removal.sv
tb/tb.sv
